// ===== rtl/core/eul_pkg.sv =====
// Shared types, constants and tables of the Euler-angle frame builder.
// No dependencies.
`timescale 1ns / 1ps
package eul_pkg;
   localparam int CordicSteps = 16;
   localparam int AngleWidth  = 16;
   localparam int AngFrac     = AngleWidth - 3;
   localparam int TableLen    = 24;
   localparam int NumSteps    = (CordicSteps < TableLen) ? CordicSteps : TableLen;
   localparam int XyWidth     = 33;
   localparam longint GainQ30   = 64'sd652032874;
   localparam longint PiQ30     = 64'sd3373259426;
   localparam longint HalfPiQ30 = 64'sd1686629713;
   localparam logic signed [15:0] OneQ14 = 16'sd16384;

   typedef logic signed [AngleWidth-1:0] ang_type;
   typedef logic signed [XyWidth-1:0]    xy_type;
   typedef logic signed [15:0]           q14_type;

   typedef struct packed {
      logic signed [15:0] angle_alpha;
      logic signed [15:0] angle_beta;
      logic signed [15:0] angle_gamma;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
   } req_type;

   typedef struct packed {
      q14_type r00; q14_type r01; q14_type r02;
      q14_type r10; q14_type r11; q14_type r12;
      q14_type r20; q14_type r21; q14_type r22;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pos_type;

   // Round a positive Q30 constant half up to the internal angle format.
   function automatic ang_type q30_to_ang(input longint c);
      longint sh;
      sh = 30 - AngFrac;
      return ang_type'((c + (64'sd1 <<< (sh - 1))) >>> sh);
   endfunction

   // Arctangent table, atan(2^-i) in Q30, truncated.
   function automatic ang_type atan_ang(input int i);
      longint t;
      case (i)
         0: t = 64'h3243F6A8;  1: t = 64'h1DAC6705;  2: t = 64'h0FADBAFC;
         3: t = 64'h07F56EA6;  4: t = 64'h03FEAB76;  5: t = 64'h01FFD55B;
         6: t = 64'h00FFFAAA;  7: t = 64'h007FFF55;  8: t = 64'h003FFFEA;
         9: t = 64'h001FFFFD; 10: t = 64'h000FFFFF; 11: t = 64'h0007FFFF;
         12: t = 64'h0003FFFF; 13: t = 64'h0001FFFF; 14: t = 64'h0000FFFF;
         15: t = 64'h00007FFF; 16: t = 64'h00003FFF; 17: t = 64'h00001FFF;
         18: t = 64'h00000FFF; 19: t = 64'h000007FF; 20: t = 64'h000003FF;
         21: t = 64'h000001FF; 22: t = 64'h000000FF; default: t = 64'h0000007F;
      endcase
      return q30_to_ang(t);
   endfunction

   // Clamp a wide value to the Q1.14 unit range.
   function automatic q14_type sat14(input logic signed [47:0] v);
      if (v > 48'sd16384) return OneQ14;
      if (v < -48'sd16384) return -OneQ14;
      return q14_type'(v);
   endfunction
endpackage

// ===== rtl/core/eul_if.sv =====
// Valid/ready channel interface for request and response beats.
// Depends on eul_pkg for the request and response payload types.
`timescale 1ns / 1ps
interface eul_req_if;
   logic               valid;
   logic               ready;
   eul_pkg::req_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface eul_rsp_if;
   logic               valid;
   logic               ready;
   eul_pkg::rsp_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/eul_cordic.sv =====
// Pipelined rotation-mode CORDIC producing saturated Q1.14 sine and cosine.
// Depends on eul_pkg. One pipeline stage per iteration plus fold and round stages.
`timescale 1ns / 1ps
module eul_cordic (
   input  logic                 clock,
   input  logic                 enable,
   input  logic signed [15:0]   angle,
   output eul_pkg::q14_type     sin_out,
   output eul_pkg::q14_type     cos_out
);
   import eul_pkg::*;

   localparam ang_type Pi_a = q30_to_ang(PiQ30);
   localparam ang_type HalfPi_a = q30_to_ang(HalfPiQ30);

   ang_type z_ff [NumSteps+1];
   xy_type  x_ff [NumSteps+1];
   xy_type  y_ff [NumSteps+1];
   logic    neg_ff [NumSteps+1];
   ang_type z_in;
   logic    neg_in;
   q14_type sin_ff, cos_ff;
   logic signed [XyWidth:0] xr_in, yr_in;

   // Scale the input angle and fold it into plus or minus pi/2.
   always_comb begin
      ang_type za;
      if (AngFrac >= 13) za = ang_type'(angle) <<< (AngFrac - 13);
      else za = ang_type'(angle >>> (13 - AngFrac));
      z_in = za;
      neg_in = 1'b0;
      if (za > HalfPi_a) begin
         z_in = ang_type'(za - Pi_a); neg_in = 1'b1;
      end else if (za < -HalfPi_a) begin
         z_in = ang_type'(za + Pi_a); neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[0] <= z_in;
         x_ff[0] <= xy_type'(GainQ30);
         y_ff[0] <= '0;
         neg_ff[0] <= neg_in;
      end
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < NumSteps; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (enable) begin
            neg_ff[i+1] <= neg_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_ang(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_ang(i);
            end
         end
      end
   end

   // Undo the fold, round to Q14 and saturate.
   always_comb begin
      logic signed [XyWidth:0] xe, ye;
      xe = (XyWidth+1)'(x_ff[NumSteps]);
      ye = (XyWidth+1)'(y_ff[NumSteps]);
      if (neg_ff[NumSteps]) begin
         xe = -xe; ye = -ye;
      end
      xr_in = (xe + (XyWidth+1)'(32768)) >>> 16;
      yr_in = (ye + (XyWidth+1)'(32768)) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= sat14(48'(xr_in));
         sin_ff <= sat14(48'(yr_in));
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule

// ===== rtl/core/eul_matrix.sv =====
// Three-stage matrix assembly: pair products, triple terms, round and saturate.
// Depends on eul_pkg.
`timescale 1ns / 1ps
module eul_matrix (
   input  logic             clock,
   input  logic             enable,
   input  eul_pkg::q14_type sa, ca, sb, cb, sc, cc,
   output eul_pkg::q14_type m_out [9]
);
   import eul_pkg::*;

   typedef logic signed [31:0] p28_type;
   typedef logic signed [47:0] p42_type;

   p28_type cbcc_ff, cbsc_ff, sacb_ff, cacb_ff, sbcc_ff, sbsc_ff, casc_ff, cacc_ff,
            sasc_ff, sacc_ff;
   q14_type sa_ff, ca_ff, sb_ff;
   p28_type cbcc2_ff, cbsc2_ff, sacb2_ff, cacb2_ff;
   p42_type t3_ff, t4_ff, t6_ff, t7_ff;
   q14_type sb2_ff;
   q14_type m_ff [9];

   // Stage one: all two-factor products.
   always_ff @(posedge clock) begin
      if (enable) begin
         cbcc_ff <= cb * cc;  cbsc_ff <= cb * sc;
         sacb_ff <= sa * cb;  cacb_ff <= ca * cb;
         sbcc_ff <= sb * cc;  sbsc_ff <= sb * sc;
         casc_ff <= ca * sc;  cacc_ff <= ca * cc;
         sasc_ff <= sa * sc;  sacc_ff <= sa * cc;
         sa_ff <= sa; ca_ff <= ca; sb_ff <= sb;
      end
   end

   // Stage two: three-factor terms summed in Q42.
   always_ff @(posedge clock) begin
      if (enable) begin
         t3_ff <= (p42_type'(sa_ff) * p42_type'(sbcc_ff)) + (p42_type'(casc_ff) <<< 14);
         t4_ff <= -(p42_type'(sa_ff) * p42_type'(sbsc_ff)) + (p42_type'(cacc_ff) <<< 14);
         t6_ff <= -(p42_type'(ca_ff) * p42_type'(sbcc_ff)) + (p42_type'(sasc_ff) <<< 14);
         t7_ff <= (p42_type'(ca_ff) * p42_type'(sbsc_ff)) + (p42_type'(sacc_ff) <<< 14);
         cbcc2_ff <= cbcc_ff; cbsc2_ff <= cbsc_ff;
         sacb2_ff <= sacb_ff; cacb2_ff <= cacb_ff;
         sb2_ff <= sb_ff;
      end
   end

   // Stage three: round half up and saturate.
   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff[0] <= sat14((48'(cbcc2_ff) + 48'sd8192) >>> 14);
         m_ff[1] <= sat14((-48'(cbsc2_ff) + 48'sd8192) >>> 14);
         m_ff[2] <= sb2_ff;
         m_ff[3] <= sat14((t3_ff + 48'sd134217728) >>> 28);
         m_ff[4] <= sat14((t4_ff + 48'sd134217728) >>> 28);
         m_ff[5] <= sat14((-48'(sacb2_ff) + 48'sd8192) >>> 14);
         m_ff[6] <= sat14((t6_ff + 48'sd134217728) >>> 28);
         m_ff[7] <= sat14((t7_ff + 48'sd134217728) >>> 28);
         m_ff[8] <= sat14((48'(cacb2_ff) + 48'sd8192) >>> 14);
      end
   end

   assign m_out = m_ff;
endmodule

// ===== rtl/core/euler_angles_to_rotation_matrix.sv =====
// Euler-angle frame builder: one X-Y-Z rotation matrix plus translation per beat.
// Depends on eul_pkg, eul_if, eul_cordic and eul_matrix.
`timescale 1ns / 1ps
// The block takes one beat per clock and returns one frame per beat, in order.
// The pipeline is one fold stage, one stage per CORDIC iteration, one rounding
// stage and three matrix stages. The whole pipeline advances when the output
// stage is empty or being taken, so back-to-back beats flow at full rate
// whenever the sink keeps ready high.
module euler_angles_to_rotation_matrix (
   input  logic      clock,
   input  logic      reset,
   eul_req_if.sink   req,
   eul_rsp_if.source rsp
);
   import eul_pkg::*;

   localparam int Latency = NumSteps + 5;

   logic            enable;
   logic [Latency-1:0] valid_ff;
   pos_type         pos_ff [Latency];
   q14_type         s_a, c_a, s_b, c_b, s_c, c_c;
   q14_type         m [9];

   // Stall everything only when the last stage holds an untaken beat.
   assign enable = !valid_ff[Latency-1] || rsp.ready;
   assign req.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[Latency-2:0], req.valid};
      end
   end

   // Translation delay line alongside the datapath.
   always_ff @(posedge clock) begin
      if (enable) begin
         pos_ff[0] <= '{req.data.offset_x, req.data.offset_y, req.data.offset_z};
         for (int k = 1; k < Latency; k++) pos_ff[k] <= pos_ff[k-1];
      end
   end

   eul_cordic u_alpha (.clock, .enable, .angle(req.data.angle_alpha),
                       .sin_out(s_a), .cos_out(c_a));
   eul_cordic u_beta  (.clock, .enable, .angle(req.data.angle_beta),
                       .sin_out(s_b), .cos_out(c_b));
   eul_cordic u_gamma (.clock, .enable, .angle(req.data.angle_gamma),
                       .sin_out(s_c), .cos_out(c_c));

   eul_matrix u_matrix (.clock, .enable, .sa(s_a), .ca(c_a), .sb(s_b), .cb(c_b),
                        .sc(s_c), .cc(c_c), .m_out(m));

   assign rsp.valid = valid_ff[Latency-1];
   assign rsp.data = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
                      pos_ff[Latency-1].x, pos_ff[Latency-1].y, pos_ff[Latency-1].z};

   // A stalled output beat keeps its place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("output beat lost");
   // Input is refused only while the output stalls.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready) else $error("spurious stall");
   // An accepted beat is captured in the first valid bit of the pipeline.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> valid_ff[0]) else $error("valid not captured");
   // Matrix entry r02 stays within the unit range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.r02 <= OneQ14) && (rsp.data.r02 >= -OneQ14))
      else $error("entry out of range");
endmodule
